### rtl/core/cfr_pkg.sv
// Package for the command framer: command item type, configuration bundle,
// register index codes and the CRC-16/MODBUS byte update.
// No dependencies.
`default_nettype none

package cfr_pkg;

    // Frame limits and CRC constants
    localparam logic [7:0]  MAX_PAYLOAD  = 8'd254;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;
    localparam logic [15:0] CRC_LSB_MASK = 16'h0001;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_START_MARKER = 2'd0;
    localparam t_cfg_idx CFG_END_MARKER   = 2'd1;
    localparam t_cfg_idx CFG_HDR_TYPE     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_START_MARKER = 8'd170;
    localparam logic [7:0] RST_END_MARKER   = 8'd85;
    localparam logic [7:0] RST_HDR_TYPE     = 8'd0;

    typedef struct packed {
        logic [7:0] start_marker;
        logic [7:0] end_marker;
        logic [7:0] hdr_type;
    } t_cfg;

    // Work queued from the front end to the byte sequencer
    typedef enum logic {
        CMD_START,
        CMD_DATA
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] byte_val;   // command code or payload byte
        logic [7:0] len;        // saturated payload length (start only)
        logic [7:0] seq;        // sequence number (start only)
        logic       close;      // frame closes after this item
    } t_cmd;

    // One byte of CRC-16/MODBUS, reflected, eight shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_LSB_MASK) != 16'h0000) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/core/cfr_ifs.sv
// Handshake interfaces of the command framer: command input, configuration
// write and byte output channels. Depends on cfr_pkg.
`default_nettype none

interface cfr_in_if;
    logic       valid;
    logic       ready;
    logic       start_frame;
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic [7:0] data_byte;

    modport source (output valid, start_frame, command_code, payload_length, data_byte,
                    input ready);
    modport sink   (input valid, start_frame, command_code, payload_length, data_byte,
                    output ready);
endinterface

interface cfr_cfg_if;
    logic                valid;
    logic                ready;
    cfr_pkg::t_cfg_idx   index;
    logic [7:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface cfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       frame_end;

    modport source (output valid, tx_byte, frame_end, input ready);
    modport sink   (input valid, tx_byte, frame_end, output ready);
endinterface

`default_nettype wire

### rtl/core/cfr_front.sv
// Front end of the command framer: accepts input items, tracks the open
// frame and sequence number, and queues start/data work. Depends on cfr_pkg, cfr_ifs.
`default_nettype none

module cfr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    cfr_in_if.sink             i_cmd,
    input  wire logic          i_full,
    output logic               o_push,
    output cfr_pkg::t_cmd      o_push_cmd
);

    logic       r_open;
    logic [7:0] r_seq;
    logic [7:0] r_rem;

    logic       n_open;
    logic [7:0] n_seq;
    logic [7:0] n_rem;

    logic       accept;
    logic [7:0] len_sat;
    logic [7:0] rem_dec;

    assign i_cmd.ready = !i_full;
    assign accept      = i_cmd.valid && i_cmd.ready;

    // Classify the item and work out the frame state after it
    always_comb begin
        len_sat = (i_cmd.payload_length > cfr_pkg::MAX_PAYLOAD) ?
                  cfr_pkg::MAX_PAYLOAD : i_cmd.payload_length;
        rem_dec = (r_rem != 8'd0) ? (r_rem - 8'd1) : 8'd0;

        n_open     = r_open;
        n_seq      = r_seq;
        n_rem      = r_rem;
        o_push     = 1'b0;
        o_push_cmd = '{kind: cfr_pkg::CMD_DATA, byte_val: i_cmd.data_byte,
                       len: len_sat, seq: r_seq, close: (rem_dec == 8'd0)};

        if (accept) begin
            if (i_cmd.start_frame) begin
                // a start abandons any open frame
                o_push              = 1'b1;
                o_push_cmd.kind     = cfr_pkg::CMD_START;
                o_push_cmd.byte_val = i_cmd.command_code;
                o_push_cmd.close    = (len_sat == 8'd0);
                n_seq  = r_seq + 8'd1;
                n_rem  = len_sat;
                n_open = (len_sat != 8'd0);
            end else if (r_open) begin
                o_push = 1'b1;
                n_rem  = rem_dec;
                if (rem_dec == 8'd0) begin
                    n_open = 1'b0;
                end
            end
            // payload outside a frame is dropped
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_seq  <= 8'd0;
            r_rem  <= 8'd0;
        end else begin
            r_open <= n_open;
            r_seq  <= n_seq;
            r_rem  <= n_rem;
        end
    end

endmodule

`default_nettype wire

### rtl/core/cfr_queue.sv
// Short work queue between front end and byte sequencer of the framer.
// Depends on cfr_pkg.
`default_nettype none

module cfr_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  cfr_pkg::t_cmd       i_push_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output cfr_pkg::t_cmd       o_head,
    output logic                o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cfr_pkg::t_cmd     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointer wrap at the queue depth
    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/core/cfr_back.sv
// Byte sequencer of the framer: expands queued work into header, payload,
// CRC and end marker bytes into a registered output. Depends on cfr_pkg, cfr_ifs.
`default_nettype none

module cfr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  cfr_pkg::t_cfg      i_cfg,
    input  cfr_pkg::t_cmd      i_head,
    input  wire logic          i_empty,
    output logic               o_pop,
    cfr_out_if.source          o_tx
);

    typedef enum logic [3:0] {
        PH_HDR_START,
        PH_HDR_SEQ,
        PH_HDR_TYPE,
        PH_HDR_LEN,
        PH_HDR_CMD,
        PH_DATA,
        PH_CRC_LO,
        PH_CRC_HI,
        PH_END
    } t_phase;

    logic          r_busy;
    t_phase        r_phase;
    cfr_pkg::t_cmd r_cmd;
    logic [15:0]   r_crc;
    logic          r_out_valid;
    logic [7:0]    r_tx_byte;
    logic          r_frame_end;

    t_phase        cur_phase;
    cfr_pkg::t_cmd cur_cmd;
    t_phase        n_phase;
    logic          n_done;
    logic [7:0]    n_byte;
    logic          n_last;
    logic          n_crc_upd;
    logic [15:0]   crc_in;
    logic [15:0]   n_crc;
    logic          stage_free;
    logic          fire;

    assign o_tx.valid     = r_out_valid;
    assign o_tx.tx_byte   = r_tx_byte;
    assign o_tx.frame_end = r_frame_end;

    // Pick the byte to emit and the phase after it
    always_comb begin
        stage_free = !r_out_valid || o_tx.ready;
        cur_cmd    = r_busy ? r_cmd : i_head;
        if (r_busy) begin
            cur_phase = r_phase;
        end else begin
            cur_phase = (i_head.kind == cfr_pkg::CMD_START) ? PH_HDR_START : PH_DATA;
        end
        fire  = stage_free && (r_busy || !i_empty);
        o_pop = fire && !r_busy;

        n_byte    = cur_cmd.byte_val;
        n_last    = 1'b0;
        n_crc_upd = 1'b1;
        n_phase   = PH_CRC_LO;
        n_done    = 1'b0;
        case (cur_phase)
            PH_HDR_START: begin
                n_byte  = i_cfg.start_marker;
                n_phase = PH_HDR_SEQ;
            end
            PH_HDR_SEQ: begin
                n_byte  = cur_cmd.seq;
                n_phase = PH_HDR_TYPE;
            end
            PH_HDR_TYPE: begin
                n_byte  = i_cfg.hdr_type;
                n_phase = PH_HDR_LEN;
            end
            PH_HDR_LEN: begin
                n_byte  = cur_cmd.len + 8'd1;
                n_phase = PH_HDR_CMD;
            end
            PH_HDR_CMD, PH_DATA: begin
                n_byte = cur_cmd.byte_val;
                n_done = !cur_cmd.close;
            end
            PH_CRC_LO: begin
                n_byte    = r_crc[7:0];
                n_crc_upd = 1'b0;
                n_phase   = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                n_byte    = r_crc[15:8];
                n_crc_upd = 1'b0;
                n_phase   = PH_END;
            end
            PH_END: begin
                n_byte    = i_cfg.end_marker;
                n_last    = 1'b1;
                n_crc_upd = 1'b0;
                n_done    = 1'b1;
            end
            default: begin
                n_crc_upd = 1'b0;
                n_done    = 1'b1;
            end
        endcase

        // CRC restarts on the start marker of each frame
        crc_in = (cur_phase == PH_HDR_START) ? cfr_pkg::CRC_INIT : r_crc;
        n_crc  = cfr_pkg::crc16_byte(crc_in, n_byte);
    end

    // Sequencer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_HDR_START;
            r_crc       <= cfr_pkg::CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
                r_tx_byte   <= n_byte;
                r_frame_end <= n_last;
                r_cmd       <= cur_cmd;
                r_phase     <= n_phase;
                r_busy      <= !n_done;
                if (n_crc_upd) begin
                    r_crc <= n_crc;
                end
            end else if (o_tx.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/crc16_uart_command_framer.sv
// Command framer with CRC-16/MODBUS: top level with configuration registers,
// front end, work queue and byte sequencer. Depends on cfr_pkg, cfr_ifs and the cfr_ modules.
//
// A start item (start_frame = 1) produces the frame header: start marker,
// sequence number, packet type, length + 1 and command code; with a zero
// length the CRC low byte, CRC high byte and end marker follow at once
// (frame_end set on the end marker). Each payload item produces its byte,
// and the last one of the frame is followed by the CRC and end marker.
// Lengths above 254 are taken as 254, payload outside a frame is dropped,
// and a start inside an open frame abandons it. Output runs at one byte per
// clock while the receiver is ready, set by the output register: a payload item
// gives one byte, a start item five (eight when empty), the last payload item
// four. Input items are taken one per clock while the QUEUE_DEPTH-entry work
// queue has room, so the input side keeps running while output is stalled.
// The first byte goes out via the work queue and output register. Configuration writes
// are always ready and must be made while the framer is idle.
`default_nettype none

module crc16_uart_command_framer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    cfr_in_if.sink      i_cmd,
    cfr_cfg_if.sink     i_cfg,
    cfr_out_if.source   o_tx
);

    cfr_pkg::t_cfg r_cfg;
    cfr_pkg::t_cmd push_cmd;
    cfr_pkg::t_cmd head_cmd;
    logic          push;
    logic          full;
    logic          pop;
    logic          empty;

    assign i_cfg.ready = 1'b1;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker <= cfr_pkg::RST_START_MARKER;
            r_cfg.end_marker   <= cfr_pkg::RST_END_MARKER;
            r_cfg.hdr_type     <= cfr_pkg::RST_HDR_TYPE;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                cfr_pkg::CFG_START_MARKER: r_cfg.start_marker <= i_cfg.data;
                cfr_pkg::CFG_END_MARKER:   r_cfg.end_marker   <= i_cfg.data;
                cfr_pkg::CFG_HDR_TYPE:     r_cfg.hdr_type     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    cfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_full     (full),
        .o_push     (push),
        .o_push_cmd (push_cmd)
    );

    cfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (full),
        .i_pop      (pop),
        .o_head     (head_cmd),
        .o_empty    (empty)
    );

    cfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_tx    (o_tx)
    );

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench for crc16_uart_command_framer: sends command and payload items,
// predicts every framed byte and checks the output stream against it.
// Depends on cfr_pkg, the cfr_ifs interfaces and the framer RTL.
`timescale 1ns / 1ps

module tb;

    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
    } t_tx_beat;

    logic i_clk;
    logic i_rst_n;

    cfr_in_if  cmd_if ();
    cfr_cfg_if cfg_if ();
    cfr_out_if tx_if ();

    crc16_uart_command_framer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .i_cfg   (cfg_if),
        .o_tx    (tx_if)
    );

    // Shadow configuration and framing state
    logic [7:0]  sh_start_marker;
    logic [7:0]  sh_end_marker;
    logic [7:0]  sh_hdr_type;
    logic [7:0]  sh_seq;
    logic [15:0] sh_crc;
    logic [7:0]  sh_left;
    logic        sh_open;

    t_tx_beat tx_due[$];

    int fail_count      = 0;
    int bytes_checked   = 0;
    int frames_closed   = 0;
    int items_sent      = 0;
    int starts_sent     = 0;
    int ignored_items   = 0;
    int gap_pct         = 0;
    int stall_pct       = 0;
    int rx_hold_request = 0;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // CRC-16/MODBUS, one byte, LSB first
    function automatic logic [15:0] modbus_crc_next(logic [15:0] crc, logic [7:0] b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        repeat (8) begin
            acc = acc[0] ? ((acc >> 1) ^ cfr_pkg::CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    function automatic void push_byte(logic [7:0] b, logic last, bit into_crc);
        t_tx_beat beat;
        beat.tx_byte   = b;
        beat.frame_end = last;
        tx_due.push_back(beat);
        if (into_crc) sh_crc = modbus_crc_next(sh_crc, b);
    endfunction

    // CRC low, CRC high, end marker
    function automatic void push_trailer();
        logic [15:0] c;
        c = sh_crc;
        push_byte(c[7:0], 1'b0, 1'b0);
        push_byte(c[15:8], 1'b0, 1'b0);
        push_byte(sh_end_marker, 1'b1, 1'b0);
        sh_open = 1'b0;
        sh_left = '0;
        frames_closed++;
    endfunction

    // Expected bytes for one accepted item
    function automatic void encode_item(logic start, logic [7:0] cmd, logic [7:0] len,
                                        logic [7:0] data);
        logic [7:0] n;
        if (start) begin
            n = (len > cfr_pkg::MAX_PAYLOAD) ? cfr_pkg::MAX_PAYLOAD : len;
            sh_crc = cfr_pkg::CRC_INIT;
            push_byte(sh_start_marker, 1'b0, 1'b1);
            push_byte(sh_seq, 1'b0, 1'b1);
            sh_seq = sh_seq + 8'd1;
            push_byte(sh_hdr_type, 1'b0, 1'b1);
            push_byte(n + 8'd1, 1'b0, 1'b1);
            push_byte(cmd, 1'b0, 1'b1);
            sh_open = 1'b1;
            sh_left = n;
            starts_sent++;
            if (n == 8'd0) push_trailer();
        end else if (sh_open) begin
            push_byte(data, 1'b0, 1'b1);
            if (sh_left != 8'd0) sh_left = sh_left - 8'd1;
            if (sh_left == 8'd0) push_trailer();
        end else begin
            ignored_items++;
        end
    endfunction

    // Present one item, with random idle cycles ahead of it
    task automatic send_item(logic start, logic [7:0] cmd, logic [7:0] len, logic [7:0] data);
        while ($urandom_range(99) < gap_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid          <= 1'b1;
        cmd_if.start_frame    <= start;
        cmd_if.command_code   <= cmd;
        cmd_if.payload_length <= len;
        cmd_if.data_byte      <= data;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        encode_item(start, cmd, len, data);
        items_sent++;
    endtask

    task automatic send_frame(logic [7:0] cmd, logic [7:0] len, int n_bytes);
        send_item(1'b1, cmd, len, 8'($urandom));
        repeat (n_bytes) send_item(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Stop sending and wait for every expected byte, then let the block go quiet
    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (tx_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers back to back; only called while idle
    task automatic write_config(logic [7:0] sm, logic [7:0] em, logic [7:0] pt);
        cfr_pkg::t_cfg_idx idx [3];
        logic [7:0]        val [3];
        idx = '{cfr_pkg::CFG_START_MARKER, cfr_pkg::CFG_END_MARKER, cfr_pkg::CFG_HDR_TYPE};
        val = '{sm, em, pt};
        for (int k = 0; k < 3; k++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[k];
            cfg_if.data  <= val[k];
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
            case (idx[k])
                cfr_pkg::CFG_START_MARKER: sh_start_marker = val[k];
                cfr_pkg::CFG_END_MARKER:   sh_end_marker   = val[k];
                cfr_pkg::CFG_HDR_TYPE:     sh_hdr_type     = val[k];
                default: ;
            endcase
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly well-formed frames, some stray payload and cut-short frames
    task automatic run_random(int budget);
        int base;
        int kind;
        int len;
        int n;
        base = items_sent - ignored_items;
        while (items_sent - ignored_items - base < budget) begin
            kind = $urandom_range(99);
            len  = $urandom_range(0, 6);
            if (kind < 8) begin
                repeat ($urandom_range(1, 3))
                    send_item(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
            end else if (kind < 16) begin
                n = (len == 0) ? 0 : $urandom_range(0, len - 1);
                send_frame(8'($urandom), 8'(len), n);
            end else begin
                send_frame(8'($urandom), 8'(len), len);
            end
        end
    endtask

    // Reset configuration, field extremes and the special cases
    task automatic test_directed_cases();
        gap_pct   = 0;
        stall_pct = 0;
        send_item(1'b1, 8'h00, 8'd0, 8'hFF);     // empty payload
        send_item(1'b0, 8'hFF, 8'hFF, 8'h11);    // payload with no frame open
        send_item(1'b1, 8'hFF, 8'd1, 8'h00);
        send_item(1'b0, 8'h00, 8'h00, 8'hFF);
        send_item(1'b1, 8'h5A, 8'd255, 8'h00);   // length saturates to 254
        send_item(1'b0, 8'h00, 8'h00, 8'h00);
        send_item(1'b0, 8'h00, 8'h00, 8'hA5);
        send_item(1'b1, 8'h3C, 8'd2, 8'h00);     // start inside an open frame
        send_item(1'b0, 8'h00, 8'h00, 8'h80);
        send_item(1'b0, 8'h00, 8'h00, 8'h01);
        send_item(1'b0, 8'hFF, 8'hFF, 8'h00);    // dropped again
        send_item(1'b1, 8'h81, 8'd254, 8'h00);
        send_item(1'b0, 8'h00, 8'h00, 8'h7F);
        send_item(1'b1, 8'h01, 8'd0, 8'h00);     // abandons into an empty frame
        send_item(1'b1, 8'h7E, 8'd3, 8'h55);
        send_item(1'b0, 8'h00, 8'h00, 8'h00);
        send_item(1'b0, 8'h00, 8'h00, 8'hFF);
        send_item(1'b0, 8'h00, 8'h00, 8'h80);
        drain();
    endtask

    // Register extremes with short and empty frames
    task automatic test_config_extremes();
        gap_pct   = 30;
        stall_pct = 30;
        write_config(8'h00, 8'h00, 8'h00);
        send_frame(8'h00, 8'd0, 0);
        send_frame(8'h42, 8'd2, 2);
        drain();
        write_config(8'hFF, 8'hFF, 8'hFF);
        send_frame(8'hC3, 8'd6, 6);
        send_frame(8'hFF, 8'd0, 0);
        drain();
        write_config(cfr_pkg::RST_START_MARKER, cfr_pkg::RST_END_MARKER,
                     cfr_pkg::RST_HDR_TYPE);
        send_frame(8'h10, 8'd1, 1);
        drain();
    endtask

    // Random traffic under four idling mixes, new settings between them
    task automatic test_random_traffic();
        int mix [4][2];
        mix = '{'{0, 0}, '{71, 0}, '{0, 71}, '{30, 30}};
        for (int p = 0; p < 4; p++) begin
            gap_pct   = mix[p][0];
            stall_pct = mix[p][1];
            write_config(8'($urandom), 8'($urandom), 8'($urandom));
            run_random(20);
            drain();
        end
    endtask

    // Long receiver hold-off while the sender keeps offering
    task automatic test_back_pressure();
        gap_pct         = 0;
        stall_pct       = 0;
        rx_hold_request = 150;
        send_frame(8'($urandom), 8'd30, 30);
        drain();
        gap_pct   = 30;
        stall_pct = 30;
        send_frame(8'($urandom), 8'd12, 12);
        drain();
    endtask

    // Enough frames for the sequence number to wrap
    task automatic test_sequence_wrap();
        gap_pct   = 30;
        stall_pct = 30;
        while (starts_sent < 258) send_item(1'b1, 8'($urandom), 8'd0, 8'($urandom));
        send_frame(8'($urandom), 8'd2, 2);
        drain();
    endtask

    // Receiver ready, with random stalls and requested hold-offs
    initial begin
        int hold_left;
        hold_left   = 0;
        tx_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_request > 0) begin
                hold_left       = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                tx_if.ready <= 1'b0;
            end else begin
                tx_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Output check against the oldest expected byte
    always @(posedge i_clk) begin
        t_tx_beat want;
        if (i_rst_n && tx_if.valid && tx_if.ready) begin
            if (tx_due.size() == 0) begin
                $error("unexpected item: tx_byte %02h frame_end %0b",
                       tx_if.tx_byte, tx_if.frame_end);
                fail_count++;
            end else begin
                want = tx_due.pop_front();
                if (tx_if.tx_byte !== want.tx_byte) begin
                    $error("tx_byte: expected %02h, got %02h", want.tx_byte, tx_if.tx_byte);
                    fail_count++;
                end
                if (tx_if.frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b, got %0b", want.frame_end, tx_if.frame_end);
                    fail_count++;
                end
                bytes_checked++;
            end
        end
    end

    // Run limit
    initial begin
        #(5_000_000);
        $display("tb: failure");
        $finish;
    end

    // Test sequence
    initial begin
        i_rst_n               = 1'b0;
        cmd_if.valid          = 1'b0;
        cmd_if.start_frame    = 1'b0;
        cmd_if.command_code   = 8'h00;
        cmd_if.payload_length = 8'h00;
        cmd_if.data_byte      = 8'h00;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = cfr_pkg::CFG_START_MARKER;
        cfg_if.data           = 8'h00;
        sh_start_marker       = cfr_pkg::RST_START_MARKER;
        sh_end_marker         = cfr_pkg::RST_END_MARKER;
        sh_hdr_type           = cfr_pkg::RST_HDR_TYPE;
        sh_seq                = 8'h00;
        sh_crc                = cfr_pkg::CRC_INIT;
        sh_left               = 8'h00;
        sh_open               = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_config_extremes();
        test_random_traffic();
        test_back_pressure();
        test_sequence_wrap();
        drain();

        $display("tb: %0d items sent (%0d frame starts, %0d dropped), %0d frames closed",
                 items_sent, starts_sent, ignored_items, frames_closed);
        $display("tb: %0d bytes checked across idling mixes, register extremes and seq wrap",
                 bytes_checked);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
